// ===== hw/rtl/pcob_pkg.sv =====
// pcob_pkg: widths, request and register codes, and the bundle types shared by the
// pair capacity offset and depth bucketer. Has no dependencies of its own.
package pcob_pkg;

   // Field widths of the request, result and register payloads.
   localparam int NQ_W   = 9;
   localparam int MM_W   = 16;
   localparam int QIDX_W = 8;
   localparam int QA_W   = 8;
   localparam int QD_W   = 4;
   localparam int OFS_W  = 31;
   localparam int TA_W   = 10;
   localparam int LI_W   = 16;
   localparam int SUM_W  = 32;
   localparam int CAP_W  = 24;
   localparam int SLOT_W = 16;
   localparam int CNT_W  = 17;
   localparam int NT_W   = 17;

   // One query table word holds {atoms, depth}.
   localparam int QENT_W = QA_W + QD_W;
   localparam int PTR_W  = NQ_W;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_CNT_W      = 3;
   localparam int RSP_PTR_W      = 2;

   localparam int DIV_CNT_W = 5;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_PAIR  = 2'd2;

   localparam logic REG_NUM_QUERIES = 1'b0;
   localparam logic REG_MAX_MATCHES = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic [OFS_W-1:0]  global_pair_index;
      logic [LI_W-1:0]   local_index;
      logic [SUM_W-1:0]  match_start;
      logic [CAP_W-1:0]  capacity;
      logic [QD_W-1:0]   depth;
      logic [SLOT_W-1:0] bucket_slot;
      logic              is_last;
      logic [SUM_W-1:0]  total_matches;
      logic [QD_W-1:0]   max_depth;
      logic [NT_W-1:0]   num_targets;
      logic              sum_overflow;
   } rsp_type;

endpackage

// ===== hw/rtl/pair_capacity_offset_and_depth_bucketer_unit.sv =====
// Pair capacity offset and depth bucketer, top level.
// Request beats (req_*) carry one of three kinds: a load writes one query table entry,
// a start opens a batch at a global pair offset, a pair brings one target atom count.
// Each pair beat, up to MAX_BATCH_PAIRS per batch, yields one response beat (rsp_*)
// with its indices, capacity, prefix sum, depth and bucket slot; the beat marked last
// also carries the batch summary. Loads and starts yield no response. num_queries and
// max_matches sit behind the csr_* port at byte addresses 0 and 4; the user must change
// them only while the block is idle, as the block itself does not enforce it.
// Throughput: one load or pair beat per cycle while the remainder unit is idle and the
// result queue has room. The query table entry for the current query pointer is
// prefetched, so a pair needs one read of the depth counter memory, one multiply in
// stage one and one add in stage two, and then enters the result queue.
// A start takes the pointer from offset mod num_queries, worked out by a bit-serial
// remainder unit: the request port stays closed while that unit works, and a start
// waits until earlier pairs have left the pipeline. Results land in a four-entry
// queue; when the receiver stalls, at most four pair beats are in flight before
// req_ready drops. Reset empties the pipeline and queue, clears all counters and sets
// num_queries to 1; the query table keeps its contents and is undefined until loaded.
module pair_capacity_offset_and_depth_bucketer_unit #(
   parameter int MAX_QUERIES     = 256,
   parameter int DEPTH_LEVELS    = 16,
   parameter int MAX_BATCH_PAIRS = 65536
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pcob_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [pcob_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [pcob_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic [pcob_pkg::QIDX_W-1:0]        req_query_index,
   input  logic [pcob_pkg::QA_W-1:0]          req_query_atoms,
   input  logic [pcob_pkg::QD_W-1:0]          req_query_depth,
   input  logic [pcob_pkg::OFS_W-1:0]         req_pair_offset,
   input  logic [pcob_pkg::TA_W-1:0]          req_target_atoms,
   input  logic                               req_last,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pcob_pkg::OFS_W-1:0]         rsp_global_pair_index,
   output logic [pcob_pkg::LI_W-1:0]          rsp_local_index,
   output logic [pcob_pkg::SUM_W-1:0]         rsp_match_start,
   output logic [pcob_pkg::CAP_W-1:0]         rsp_capacity,
   output logic [pcob_pkg::QD_W-1:0]          rsp_depth,
   output logic [pcob_pkg::SLOT_W-1:0]        rsp_bucket_slot,
   output logic                               rsp_is_last,
   output logic [pcob_pkg::SUM_W-1:0]         rsp_total_matches,
   output logic [pcob_pkg::QD_W-1:0]          rsp_max_depth,
   output logic [pcob_pkg::NT_W-1:0]          rsp_num_targets,
   output logic                               rsp_sum_overflow
);

   localparam int NQ_W   = pcob_pkg::NQ_W;
   localparam int MM_W   = pcob_pkg::MM_W;
   localparam int QA_W   = pcob_pkg::QA_W;
   localparam int QD_W   = pcob_pkg::QD_W;
   localparam int OFS_W  = pcob_pkg::OFS_W;
   localparam int LI_W   = pcob_pkg::LI_W;
   localparam int SUM_W  = pcob_pkg::SUM_W;
   localparam int CAP_W  = pcob_pkg::CAP_W;
   localparam int SLOT_W = pcob_pkg::SLOT_W;
   localparam int CNT_W  = pcob_pkg::CNT_W;
   localparam int NT_W   = pcob_pkg::NT_W;
   localparam int PTR_W  = pcob_pkg::PTR_W;
   localparam int QENT_W = pcob_pkg::QENT_W;
   localparam int CSR_DW = pcob_pkg::CSR_DW;
   localparam int RCW    = pcob_pkg::RSP_CNT_W;

   // Loads can only address the first 2^QIDX_W entries.
   localparam int TBL_LIMIT = 1 << pcob_pkg::QIDX_W;
   localparam int TBL_DEPTH = (MAX_QUERIES < TBL_LIMIT) ? MAX_QUERIES : TBL_LIMIT;
   localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   localparam int DL_AW     = (DEPTH_LEVELS > 1) ? $clog2(DEPTH_LEVELS) : 1;
   localparam int DX_W      = DL_AW + QD_W;
   localparam int LC_W      = $clog2(MAX_BATCH_PAIRS + 1);

   // ------------------------------------------------------------------ registers port
   logic [NQ_W-1:0] nq_cfg_ff, nq_cfg_in;
   logic [MM_W-1:0] mm_cfg_ff, mm_cfg_in;
   logic            csr_wr;
   logic            csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      nq_cfg_in = nq_cfg_ff;
      mm_cfg_in = mm_cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            pcob_pkg::REG_NUM_QUERIES: nq_cfg_in = csr_pwdata[NQ_W-1:0];
            pcob_pkg::REG_MAX_MATCHES: mm_cfg_in = csr_pwdata[MM_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         pcob_pkg::REG_NUM_QUERIES: csr_prdata = CSR_DW'(nq_cfg_ff);
         pcob_pkg::REG_MAX_MATCHES: csr_prdata = CSR_DW'(mm_cfg_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nq_cfg_ff <= NQ_W'(1);
         mm_cfg_ff <= '0;
      end else begin
         nq_cfg_ff <= nq_cfg_in;
         mm_cfg_ff <= mm_cfg_in;
      end
   end

   logic [NQ_W-1:0] nq_eff;

   always_comb begin
      if (nq_cfg_ff == '0) begin
         nq_eff = NQ_W'(1);
      end else if (32'(nq_cfg_ff) > MAX_QUERIES) begin
         nq_eff = NQ_W'(MAX_QUERIES);
      end else begin
         nq_eff = nq_cfg_ff;
      end
   end

   // ------------------------------------------------------------------ batch state
   logic [PTR_W-1:0]  qptr_ff, qptr_in;
   logic [LC_W-1:0]   lc_ff, lc_in;
   logic [NT_W-1:0]   span_ff, span_in;
   logic [QD_W-1:0]   maxd_ff, maxd_in;
   logic [OFS_W-1:0]  base_ff, base_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              ovf_ff, ovf_in;

   // Pipeline stage one: multiply operands and bucket lookup in flight.
   logic              s1_valid_ff, s1_valid_in;
   logic [MM_W-1:0]   s1_factor_ff, s1_factor_in;
   logic [QA_W-1:0]   s1_qa_ff, s1_qa_in;
   logic [QD_W-1:0]   s1_depth_ff, s1_depth_in;
   logic [OFS_W-1:0]  s1_gpi_ff, s1_gpi_in;
   logic [LI_W-1:0]   s1_li_ff, s1_li_in;
   logic              s1_last_ff, s1_last_in;
   logic [QD_W-1:0]   s1_maxd_ff, s1_maxd_in;
   logic [NT_W-1:0]   s1_nt_ff, s1_nt_in;

   // Pipeline stage two: capacity known, prefix sum taken here.
   logic              s2_valid_ff, s2_valid_in;
   logic [CAP_W-1:0]  s2_cap_ff, s2_cap_in;
   logic [SLOT_W-1:0] s2_slot_ff, s2_slot_in;
   logic [QD_W-1:0]   s2_depth_ff, s2_depth_in;
   logic [OFS_W-1:0]  s2_gpi_ff, s2_gpi_in;
   logic [LI_W-1:0]   s2_li_ff, s2_li_in;
   logic              s2_last_ff, s2_last_in;
   logic [QD_W-1:0]   s2_maxd_ff, s2_maxd_in;
   logic [NT_W-1:0]   s2_nt_ff, s2_nt_in;

   // ------------------------------------------------------------------ submodules
   pcob_pkg::div_status_type div_status;
   logic [NQ_W-1:0]          div_rem;
   logic                     start_go;

   pcob_rem_div u_rem_div (
      .clock     (clock),
      .reset     (reset),
      .start     (start_go),
      .dividend  (req_pair_offset),
      .divisor   (nq_eff),
      .status    (div_status),
      .remainder (div_rem)
   );

   logic                load_go;
   logic [TBL_AW-1:0]   qram_rd_addr;
   logic [QENT_W-1:0]   qram_rd;

   // The table is always read at the next pointer value, so the word for the
   // current pointer is ready when a pair beat arrives.
   assign qram_rd_addr = reset ? '0 : qptr_in[TBL_AW-1:0];

   pcob_query_ram #(
      .DEPTH (TBL_DEPTH)
   ) u_query_ram (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (req_query_index[TBL_AW-1:0]),
      .wr_data ({req_query_atoms, req_query_depth}),
      .rd_addr (qram_rd_addr),
      .rd_data (qram_rd)
   );

   logic [DX_W-1:0]   d_ext;
   logic [DX_W-1:0]   s1_d_ext;
   logic [CNT_W-1:0]  cram_rd;
   logic [CNT_W-1:0]  slot_next;

   assign slot_next = cram_rd + 1'b1;

   pcob_count_ram #(
      .DEPTH (DEPTH_LEVELS)
   ) u_count_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (start_go),
      .rd_addr (d_ext[DL_AW-1:0]),
      .rd_data (cram_rd),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_d_ext[DL_AW-1:0]),
      .wr_data (slot_next)
   );

   pcob_pkg::rsp_type  push_data;
   pcob_pkg::rsp_type  out_data;
   logic [RCW-1:0]     fifo_cnt;

   pcob_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (push_data),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .count     (fifo_cnt)
   );

   // ------------------------------------------------------------------ request side
   logic             div_idle;
   logic             pipe_empty;
   logic [RCW-1:0]   occupancy;
   logic             accept;
   logic             pair_go;

   assign div_idle   = !div_status.busy && !div_status.done;
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign occupancy  = fifo_cnt + RCW'(s1_valid_ff) + RCW'(s2_valid_ff);

   // Every beat in flight has a queue slot reserved before it is taken.
   assign req_ready = div_idle && (occupancy < RCW'(pcob_pkg::RSP_FIFO_DEPTH)) &&
                      (pipe_empty || (req_type != pcob_pkg::REQ_START));
   assign accept    = req_valid && req_ready;
   assign load_go   = accept && (req_type == pcob_pkg::REQ_LOAD) &&
                      (32'(req_query_index) < MAX_QUERIES);
   assign start_go  = accept && (req_type == pcob_pkg::REQ_START);
   assign pair_go   = accept && (req_type == pcob_pkg::REQ_PAIR) &&
                      (32'(lc_ff) < MAX_BATCH_PAIRS);

   logic [QA_W-1:0]  q_atoms;
   logic [QD_W-1:0]  q_depth_raw;
   logic [QD_W-1:0]  d_sat;
   logic [QD_W-1:0]  max_new;
   logic [PTR_W:0]   ptr_inc;
   logic             ptr_wrap;

   always_comb begin
      q_atoms     = qram_rd[QENT_W-1:QD_W];
      q_depth_raw = qram_rd[QD_W-1:0];
      if (32'(q_depth_raw) >= DEPTH_LEVELS) begin
         d_sat = QD_W'(DEPTH_LEVELS - 1);
      end else begin
         d_sat = q_depth_raw;
      end
      d_ext    = DX_W'(d_sat);
      s1_d_ext = DX_W'(s1_depth_ff);
      max_new  = (d_sat > maxd_ff) ? d_sat : maxd_ff;
      ptr_inc  = {1'b0, qptr_ff} + 1'b1;
      ptr_wrap = (ptr_inc >= {1'b0, nq_eff});
   end

   always_comb begin
      qptr_in = qptr_ff;
      lc_in   = lc_ff;
      span_in = span_ff;
      maxd_in = maxd_ff;
      base_in = base_ff;
      if (div_status.done) begin
         qptr_in = div_rem;
      end else if (pair_go) begin
         qptr_in = ptr_wrap ? '0 : ptr_inc[PTR_W-1:0];
      end
      if (start_go) begin
         lc_in   = '0;
         span_in = '0;
         maxd_in = '0;
         base_in = req_pair_offset;
      end else if (pair_go) begin
         lc_in   = lc_ff + 1'b1;
         span_in = ptr_wrap ? span_ff + 1'b1 : span_ff;
         maxd_in = max_new;
      end
   end

   // Stage one loads on every accepted pair within the batch limit.
   always_comb begin
      s1_valid_in  = pair_go;
      s1_factor_in = (mm_cfg_ff != '0) ? mm_cfg_ff : MM_W'(req_target_atoms);
      s1_qa_in     = q_atoms;
      s1_depth_in  = d_sat;
      s1_gpi_in    = base_ff + OFS_W'(lc_ff);
      s1_li_in     = LI_W'(lc_ff);
      s1_last_in   = req_last;
      s1_maxd_in   = max_new;
      s1_nt_in     = span_ff + 1'b1;
   end

   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_cap_in   = CAP_W'(s1_factor_ff) * CAP_W'(s1_qa_ff);
      s2_slot_in  = cram_rd[SLOT_W-1:0];
      s2_depth_in = s1_depth_ff;
      s2_gpi_in   = s1_gpi_ff;
      s2_li_in    = s1_li_ff;
      s2_last_in  = s1_last_ff;
      s2_maxd_in  = s1_maxd_ff;
      s2_nt_in    = s1_nt_ff;
   end

   logic [SUM_W:0]    sum_ext;
   logic [SUM_W-1:0]  sum_after;
   logic              ovf_after;

   always_comb begin
      sum_ext   = {1'b0, sum_ff} + (SUM_W + 1)'(s2_cap_ff);
      sum_after = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      ovf_after = ovf_ff || sum_ext[SUM_W];
      sum_in    = sum_ff;
      ovf_in    = ovf_ff;
      if (start_go) begin
         sum_in = '0;
         ovf_in = 1'b0;
      end else if (s2_valid_ff) begin
         sum_in = sum_after;
         ovf_in = ovf_after;
      end
   end

   always_comb begin
      push_data.global_pair_index = s2_gpi_ff;
      push_data.local_index       = s2_li_ff;
      push_data.match_start       = sum_ff;
      push_data.capacity          = s2_cap_ff;
      push_data.depth             = s2_depth_ff;
      push_data.bucket_slot       = s2_slot_ff;
      push_data.is_last           = s2_last_ff;
      push_data.total_matches     = s2_last_ff ? sum_after : '0;
      push_data.max_depth         = s2_last_ff ? s2_maxd_ff : '0;
      push_data.num_targets       = s2_last_ff ? s2_nt_ff : '0;
      push_data.sum_overflow      = ovf_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qptr_ff     <= '0;
         lc_ff       <= '0;
         span_ff     <= '0;
         maxd_ff     <= '0;
         base_ff     <= '0;
         sum_ff      <= '0;
         ovf_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         qptr_ff     <= qptr_in;
         lc_ff       <= lc_in;
         span_ff     <= span_in;
         maxd_ff     <= maxd_in;
         base_ff     <= base_in;
         sum_ff      <= sum_in;
         ovf_ff      <= ovf_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_factor_ff <= s1_factor_in;
      s1_qa_ff     <= s1_qa_in;
      s1_depth_ff  <= s1_depth_in;
      s1_gpi_ff    <= s1_gpi_in;
      s1_li_ff     <= s1_li_in;
      s1_last_ff   <= s1_last_in;
      s1_maxd_ff   <= s1_maxd_in;
      s1_nt_ff     <= s1_nt_in;
      s2_cap_ff    <= s2_cap_in;
      s2_slot_ff   <= s2_slot_in;
      s2_depth_ff  <= s2_depth_in;
      s2_gpi_ff    <= s2_gpi_in;
      s2_li_ff     <= s2_li_in;
      s2_last_ff   <= s2_last_in;
      s2_maxd_ff   <= s2_maxd_in;
      s2_nt_ff     <= s2_nt_in;
   end

   // ------------------------------------------------------------------ response side
   assign rsp_global_pair_index = out_data.global_pair_index;
   assign rsp_local_index       = out_data.local_index;
   assign rsp_match_start       = out_data.match_start;
   assign rsp_capacity          = out_data.capacity;
   assign rsp_depth             = out_data.depth;
   assign rsp_bucket_slot       = out_data.bucket_slot;
   assign rsp_is_last           = out_data.is_last;
   assign rsp_total_matches     = out_data.total_matches;
   assign rsp_max_depth         = out_data.max_depth;
   assign rsp_num_targets       = out_data.num_targets;
   assign rsp_sum_overflow      = out_data.sum_overflow;

   // ------------------------------------------------------------------ assertions
   a_no_beat_while_dividing: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !(req_valid && req_ready))
      else $error("request beat taken while the remainder unit is busy");

   a_ptr_from_remainder: assert property (@(posedge clock) disable iff (reset)
      div_status.done |=> (qptr_ff == $past(div_rem)))
      else $error("query pointer not loaded from the remainder at batch start");

   a_queue_has_room: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (fifo_cnt < RCW'(pcob_pkg::RSP_FIFO_DEPTH)))
      else $error("result pushed into a full queue");

   a_depth_in_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (32'(s1_depth_ff) < DEPTH_LEVELS))
      else $error("bucket depth beyond the configured levels");

endmodule

// ===== hw/rtl/pcob_rem_div.sv =====
// pcob_rem_div: bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on pcob_pkg for widths and the status bundle.
module pcob_rem_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pcob_pkg::OFS_W-1:0]       dividend,
   input  logic [pcob_pkg::NQ_W-1:0]        divisor,
   output pcob_pkg::div_status_type         status,
   output logic [pcob_pkg::NQ_W-1:0]        remainder
);

   localparam int OW = pcob_pkg::OFS_W;
   localparam int NW = pcob_pkg::NQ_W;
   localparam int CW = pcob_pkg::DIV_CNT_W;

   logic [OW-1:0] dvd_ff, dvd_in;
   logic [NW-1:0] dsr_ff, dsr_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [NW:0]   trial;

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[OW-1]};
      if (start) begin
         dvd_in = dividend;
         dsr_in = divisor;
         rem_in = '0;
         cnt_in = CW'(OW);
      end else if (cnt_ff != '0) begin
         // The partial remainder stays below the divisor, so one subtract suffices.
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = NW'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[NW-1:0];
         end
         dvd_in  = {dvd_ff[OW-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

// ===== hw/rtl/pcob_query_ram.sv =====
// pcob_query_ram: query table memory, one write and one registered read per cycle,
// with write-first forwarding. Depends on pcob_pkg for the entry width.
module pcob_query_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [pcob_pkg::QENT_W-1:0]   wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [pcob_pkg::QENT_W-1:0]   rd_data
);

   logic [pcob_pkg::QENT_W-1:0] mem [DEPTH];
   logic [pcob_pkg::QENT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pcob_count_ram.sv =====
// pcob_count_ram: per-depth bucket counters in a memory with registered read,
// write-first forwarding and one valid bit per entry for the clear at batch start.
// Depends on pcob_pkg for the counter width.
module pcob_count_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic [AW-1:0]                rd_addr,
   output logic [pcob_pkg::CNT_W-1:0]   rd_data,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [pcob_pkg::CNT_W-1:0]   wr_data
);

   logic [pcob_pkg::CNT_W-1:0] mem [DEPTH];
   logic [pcob_pkg::CNT_W-1:0] rd_data_ff;
   logic [DEPTH-1:0]           valid_ff, valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // An entry not written since the last clear reads as zero.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else if (valid_ff[rd_addr]) begin
         rd_data_ff <= mem[rd_addr];
      end else begin
         rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pcob_rsp_fifo.sv =====
// pcob_rsp_fifo: small result queue that decouples the pipeline from the receiver.
// Depends on pcob_pkg for the result bundle and queue sizes.
module pcob_rsp_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  pcob_pkg::rsp_type                  push_data,
   input  logic                               pop,
   output logic                               out_valid,
   output pcob_pkg::rsp_type                  out_data,
   output logic [pcob_pkg::RSP_CNT_W-1:0]     count
);

   localparam int PW = pcob_pkg::RSP_PTR_W;
   localparam int CW = pcob_pkg::RSP_CNT_W;

   pcob_pkg::rsp_type slots_ff [pcob_pkg::RSP_FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pop_go;

   always_comb begin
      pop_go    = pop && (cnt_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_go ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CW'(push) - CW'(pop_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = slots_ff[rd_ptr_ff];
   assign count     = cnt_ff;

endmodule
